// ===== src/dfrw_pkg.sv =====
// Package for the delayed-feedback random walk: field widths, codes,
// register reset values and the shared control and configuration types.
// No dependencies; every other file of the block refers to it.
package dfrw_pkg;

  // Defaults for the top-level parameters.
  localparam int HALF_RANGE_DEF = 10;
  localparam int MAX_DELAY_DEF  = 8;

  // Fixed field widths.
  localparam int OP_W       = 2;
  localparam int RAND_W     = 32;
  localparam int THR_W      = 4;
  localparam int DLY_W      = 4;
  localparam int WARM_W     = 32;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int STEP_W     = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_STEP    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_A   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_B   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 2'd3;

  // Register reset values.
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 4'd0;
  localparam logic [DLY_W-1:0]  DELAY_A_RST   = 4'd2;
  localparam logic [DLY_W-1:0]  DELAY_B_RST   = 4'd0;
  localparam logic [WARM_W-1:0] WARMUP_RST    = 32'd10000;

  // A random fraction below this value counts as below one half.
  localparam logic [RAND_W-1:0] RAND_HALF = 32'h8000_0000;

  // Configuration register set.
  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [DLY_W-1:0]  delay_a;
    logic [DLY_W-1:0]  delay_b;
    logic [WARM_W-1:0] warmup;
  } dfrw_cfg_t;

  // Operation strobes for the request being executed this cycle.
  typedef struct packed {
    logic step;
    logic restart;
    logic read;
  } dfrw_ctl_t;

  // Limit a delay to the depth of the position history.
  function automatic int clamp_delay(input logic [DLY_W-1:0] d, input int maxd);
    int dv;
    dv = int'(d);
    return (dv > maxd) ? maxd : dv;
  endfunction

endpackage

// ===== src/dfrw_cfg.sv =====
// Configuration registers of the delayed-feedback random walk.
// Depends on dfrw_pkg for widths, register indexes and reset values.
module dfrw_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dfrw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfrw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output dfrw_pkg::dfrw_cfg_t              cfg
);

  dfrw_pkg::dfrw_cfg_t cfg_r;
  dfrw_pkg::dfrw_cfg_t cfg_nxt;

  // Decode the register index and merge the written value.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dfrw_pkg::CFG_THRESHOLD: cfg_nxt.threshold = cfg_wdata[dfrw_pkg::THR_W-1:0];
        dfrw_pkg::CFG_DELAY_A:   cfg_nxt.delay_a   = cfg_wdata[dfrw_pkg::DLY_W-1:0];
        dfrw_pkg::CFG_DELAY_B:   cfg_nxt.delay_b   = cfg_wdata[dfrw_pkg::DLY_W-1:0];
        dfrw_pkg::CFG_WARMUP:    cfg_nxt.warmup    = cfg_wdata[dfrw_pkg::WARM_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= dfrw_pkg::THRESHOLD_RST;
      cfg_r.delay_a   <= dfrw_pkg::DELAY_A_RST;
      cfg_r.delay_b   <= dfrw_pkg::DELAY_B_RST;
      cfg_r.warmup    <= dfrw_pkg::WARMUP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/dfrw_walk.sv =====
// Position history shift line, delayed-feedback decision and saturating
// position update. Depends on dfrw_pkg for types, widths and constants.
module dfrw_walk #(
  parameter int HALF_RANGE = dfrw_pkg::HALF_RANGE_DEF,
  parameter int MAX_DELAY  = dfrw_pkg::MAX_DELAY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dfrw_pkg::dfrw_ctl_t                   ctl,
  input  dfrw_pkg::dfrw_cfg_t                   cfg,
  input  logic [dfrw_pkg::RAND_W-1:0]           rand_fraction,
  output logic signed [$clog2(HALF_RANGE+1):0]  pos_nxt
);

  localparam int PW   = $clog2(HALF_RANGE + 1) + 1;
  localparam int DW   = $clog2(MAX_DELAY + 1);
  localparam int CMPW = ((PW > dfrw_pkg::THR_W) ? PW : dfrw_pkg::THR_W) + 1;
  localparam logic signed [PW:0] HR_P = (PW+1)'(HALF_RANGE);
  localparam logic signed [PW:0] HR_N = -HR_P;

  // Entry 0 is the current position, entry i is the position i steps back.
  logic signed [PW-1:0]   hist_r   [MAX_DELAY+1];
  logic signed [PW-1:0]   hist_nxt [MAX_DELAY+1];
  logic signed [CMPW-1:0] hist_x   [MAX_DELAY+1];
  logic [MAX_DELAY:0]     le_vec;
  logic [MAX_DELAY:0]     ge_vec;
  logic signed [CMPW-1:0] thr_s;
  logic [DW-1:0]          da_c;
  logic [DW-1:0]          db_c;
  logic                   term_a;
  logic                   term_b;
  logic                   up;
  logic signed [PW:0]     pos_ext;
  logic signed [PW:0]     pos_mov;
  logic signed [PW-1:0]   step_pos;

  // Compare every tap against the threshold in parallel, then pick by delay.
  always_comb begin
    thr_s = signed'({{(CMPW-dfrw_pkg::THR_W){1'b0}}, cfg.threshold});
    for (int i = 0; i <= MAX_DELAY; i++) begin
      hist_x[i] = CMPW'(hist_r[i]);
      le_vec[i] = (hist_x[i] <= thr_s);
      ge_vec[i] = (hist_x[i] >= -thr_s);
    end
    da_c   = DW'(dfrw_pkg::clamp_delay(cfg.delay_a, MAX_DELAY));
    db_c   = DW'(dfrw_pkg::clamp_delay(cfg.delay_b, MAX_DELAY));
    term_a = le_vec[da_c];
    term_b = ge_vec[db_c];
  end

  // Direction: feedback terms decide unless they agree, then the coin does.
  always_comb begin
    if (term_a && !term_b) begin
      up = 1'b1;
    end else if (term_b && !term_a) begin
      up = 1'b0;
    end else begin
      up = (rand_fraction < dfrw_pkg::RAND_HALF);
    end
    pos_ext = (PW+1)'(hist_r[0]);
    pos_mov = up ? (pos_ext + (PW+1)'(1)) : (pos_ext - (PW+1)'(1));
    if (pos_mov > HR_P) begin
      step_pos = PW'(HR_P);
    end else if (pos_mov < HR_N) begin
      step_pos = PW'(HR_N);
    end else begin
      step_pos = PW'(pos_mov);
    end
  end

  // Restart reloads the history; a step shifts the new position in.
  always_comb begin
    for (int i = 0; i <= MAX_DELAY; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    if (ctl.restart) begin
      for (int i = 1; i <= MAX_DELAY; i++) begin
        hist_nxt[i] = '0;
      end
      hist_nxt[0] = PW'(1);
    end else if (ctl.step) begin
      for (int i = 1; i <= MAX_DELAY; i++) begin
        hist_nxt[i] = hist_r[i-1];
      end
      hist_nxt[0] = step_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= MAX_DELAY; i++) begin
        hist_r[i] <= '0;
      end
      hist_r[0] <= PW'(1);
    end else begin
      for (int i = 0; i <= MAX_DELAY; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

  assign pos_nxt = hist_nxt[0];

endmodule

// ===== src/dfrw_stats.sv =====
// Visit histogram, saturating step index and saturating position sum.
// Depends on dfrw_pkg for types, widths, reset values and the delay clamp.
module dfrw_stats #(
  parameter int HALF_RANGE = dfrw_pkg::HALF_RANGE_DEF,
  parameter int MAX_DELAY  = dfrw_pkg::MAX_DELAY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dfrw_pkg::dfrw_ctl_t                    ctl,
  input  dfrw_pkg::dfrw_cfg_t                    cfg,
  input  logic signed [$clog2(HALF_RANGE+1):0]   step_pos,
  input  logic [$clog2(2*HALF_RANGE+1)-1:0]      rd_bin,
  output logic [dfrw_pkg::CNT_W-1:0]             bin_count,
  output logic signed [dfrw_pkg::SUM_W-1:0]      sum_nxt,
  output logic [dfrw_pkg::STEP_W-1:0]            step_nxt
);

  localparam int PW    = $clog2(HALF_RANGE + 1) + 1;
  localparam int NBINS = 2 * HALF_RANGE + 1;
  localparam int BW    = $clog2(NBINS);
  localparam int SW    = dfrw_pkg::SUM_W;
  localparam int DLY_MAXW = $clog2(MAX_DELAY + 1);
  localparam int RST_DA = dfrw_pkg::clamp_delay(dfrw_pkg::DELAY_A_RST, MAX_DELAY);
  localparam int RST_DB = dfrw_pkg::clamp_delay(dfrw_pkg::DELAY_B_RST, MAX_DELAY);
  localparam int RST_STEP = (RST_DA > RST_DB) ? RST_DA : RST_DB;
  localparam int RST_SUM  = (RST_STEP >= int'(dfrw_pkg::WARMUP_RST)) ? 1 : 0;
  localparam logic [dfrw_pkg::STEP_W-1:0] STEP_MAX = '1;
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [dfrw_pkg::CNT_W-1:0]  visit_r [NBINS];
  logic [dfrw_pkg::STEP_W-1:0] step_r;
  logic signed [SW-1:0]        sum_r;
  logic signed [PW:0]          bin_x;
  logic [BW-1:0]               step_bin;
  logic [BW-1:0]               rd_addr;
  logic                        rd_ok;
  logic [BW-1:0]               rd_idx;
  logic [dfrw_pkg::CNT_W-1:0]  rd_data;
  logic [dfrw_pkg::CNT_W-1:0]  cnt_inc;
  logic [DLY_MAXW-1:0]         init_step;
  logic signed [SW:0]          sum_add;
  logic signed [SW-1:0]        sum_sat;

  // One histogram read port: the visited bin on a step, else the requested bin.
  always_comb begin
    bin_x    = (PW+1)'(step_pos) + (PW+1)'(HALF_RANGE);
    step_bin = BW'(bin_x);
    rd_addr  = ctl.step ? step_bin : rd_bin;
    rd_ok    = ctl.step || (int'(rd_bin) < NBINS);
    rd_idx   = rd_ok ? rd_addr : '0;
    rd_data  = visit_r[rd_idx];
    cnt_inc  = (rd_data == '1) ? rd_data : (rd_data + 1'b1);
    if (ctl.step) begin
      bin_count = cnt_inc;
    end else if (ctl.read && rd_ok) begin
      bin_count = rd_data;
    end else begin
      bin_count = '0;
    end
  end

  // Step index and running sum; a restart counts the initial position.
  always_comb begin
    init_step = DLY_MAXW'((dfrw_pkg::clamp_delay(cfg.delay_a, MAX_DELAY) >
                           dfrw_pkg::clamp_delay(cfg.delay_b, MAX_DELAY)) ?
                          dfrw_pkg::clamp_delay(cfg.delay_a, MAX_DELAY) :
                          dfrw_pkg::clamp_delay(cfg.delay_b, MAX_DELAY));
    sum_add = {sum_r[SW-1], sum_r} + (SW+1)'(step_pos);
    if (sum_add[SW] != sum_add[SW-1]) begin
      sum_sat = sum_add[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_add[SW-1:0];
    end
    step_nxt = step_r;
    sum_nxt  = sum_r;
    if (ctl.restart) begin
      step_nxt = dfrw_pkg::STEP_W'(init_step);
      sum_nxt  = (step_nxt >= dfrw_pkg::STEP_W'(cfg.warmup)) ? SW'(1) : '0;
    end else if (ctl.step) begin
      step_nxt = (step_r == STEP_MAX) ? step_r : (step_r + 1'b1);
      if (step_nxt >= dfrw_pkg::STEP_W'(cfg.warmup)) begin
        sum_nxt = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dfrw_pkg::STEP_W'(RST_STEP);
      sum_r  <= SW'(RST_SUM);
    end else begin
      step_r <= step_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Histogram counters: cleared all at once by reset or restart.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NBINS; i++) begin
        visit_r[i] <= '0;
      end
    end else if (ctl.restart) begin
      for (int i = 0; i < NBINS; i++) begin
        visit_r[i] <= '0;
      end
    end else if (ctl.step) begin
      for (int i = 0; i < NBINS; i++) begin
        if (BW'(i) == step_bin) begin
          visit_r[i] <= cnt_inc;
        end
      end
    end
  end

endmodule

// ===== src/delayed_feedback_random_walk.sv =====
// Bounded random walk with delayed feedback: top level with the request
// and result registers. Depends on dfrw_pkg, dfrw_cfg, dfrw_walk, dfrw_stats.
//
// One request (step, restart or histogram read) is taken every clock cycle
// while in_stall is low, which it is unless a stalled result blocks the
// held request; the request register feeds combinational logic into the
// result register. The rate is set by the update loop through the position
// history, the visited-bin counter and the running sum. The histogram
// counters are flip-flops cleared in the reset or restart cycle, so the
// block needs no clearing pass and accepts requests right after reset.
// Configuration writes must only be issued while no request is in flight.
module delayed_feedback_random_walk #(
  parameter int HALF_RANGE = dfrw_pkg::HALF_RANGE_DEF,
  parameter int MAX_DELAY  = dfrw_pkg::MAX_DELAY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [dfrw_pkg::OP_W-1:0]              in_opcode,
  input  logic [dfrw_pkg::RAND_W-1:0]            in_rand_fraction,
  input  logic [$clog2(2*HALF_RANGE+1)-1:0]      in_bin_index,
  // Result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [$clog2(HALF_RANGE+1):0]   out_position,
  output logic [dfrw_pkg::CNT_W-1:0]             out_bin_count,
  output logic signed [dfrw_pkg::SUM_W-1:0]      out_position_sum,
  output logic [dfrw_pkg::STEP_W-1:0]            out_step_count,
  // Configuration write port
  input  logic                                   cfg_we,
  input  logic [dfrw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dfrw_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int PW = $clog2(HALF_RANGE + 1) + 1;
  localparam int BW = $clog2(2 * HALF_RANGE + 1);

  logic                        in_valid_r;
  logic [dfrw_pkg::OP_W-1:0]   op_r;
  logic [dfrw_pkg::RAND_W-1:0] rand_r;
  logic [BW-1:0]               bin_r;
  logic                        adv;
  dfrw_pkg::dfrw_ctl_t         ctl;
  dfrw_pkg::dfrw_cfg_t         cfg;
  logic signed [PW-1:0]        pos_nxt;
  logic [dfrw_pkg::CNT_W-1:0]  bin_count;
  logic signed [dfrw_pkg::SUM_W-1:0] sum_nxt;
  logic [dfrw_pkg::STEP_W-1:0] step_nxt;

  logic                        out_valid_r;
  logic signed [PW-1:0]        out_position_r;
  logic [dfrw_pkg::CNT_W-1:0]  out_bin_count_r;
  logic signed [dfrw_pkg::SUM_W-1:0] out_position_sum_r;
  logic [dfrw_pkg::STEP_W-1:0] out_step_count_r;

  // The held request executes when the result register is free or draining.
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  // Operation decode for the executing request.
  always_comb begin
    ctl.step    = 1'b0;
    ctl.restart = 1'b0;
    ctl.read    = 1'b0;
    if (adv) begin
      unique case (op_r)
        dfrw_pkg::OP_STEP:    ctl.step    = 1'b1;
        dfrw_pkg::OP_RESTART: ctl.restart = 1'b1;
        dfrw_pkg::OP_READ:    ctl.read    = 1'b1;
        default:              ctl.step    = 1'b0;
      endcase
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r   <= in_opcode;
      rand_r <= in_rand_fraction;
      bin_r  <= in_bin_index;
    end
  end

  dfrw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dfrw_walk #(
    .HALF_RANGE (HALF_RANGE),
    .MAX_DELAY  (MAX_DELAY)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cfg           (cfg),
    .rand_fraction (rand_r),
    .pos_nxt       (pos_nxt)
  );

  dfrw_stats #(
    .HALF_RANGE (HALF_RANGE),
    .MAX_DELAY  (MAX_DELAY)
  ) u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cfg       (cfg),
    .step_pos  (pos_nxt),
    .rd_bin    (bin_r),
    .bin_count (bin_count),
    .sum_nxt   (sum_nxt),
    .step_nxt  (step_nxt)
  );

  // Result register: loads on execution, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_position_r     <= pos_nxt;
      out_bin_count_r    <= bin_count;
      out_position_sum_r <= sum_nxt;
      out_step_count_r   <= step_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_position_r;
  assign out_bin_count    = out_bin_count_r;
  assign out_position_sum = out_position_sum_r;
  assign out_step_count   = out_step_count_r;

endmodule

// ===== src/dfrw_chk.sv =====
// Port-level checker for the delayed-feedback random walk, bound to the
// top level. Depends on dfrw_pkg for widths.
module dfrw_chk #(
  parameter int HALF_RANGE = dfrw_pkg::HALF_RANGE_DEF,
  parameter int MAX_DELAY  = dfrw_pkg::MAX_DELAY_DEF
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [$clog2(HALF_RANGE+1):0]   out_position,
  input logic [dfrw_pkg::CNT_W-1:0]             out_bin_count,
  input logic signed [dfrw_pkg::SUM_W-1:0]      out_position_sum,
  input logic [dfrw_pkg::STEP_W-1:0]            out_step_count
);

  localparam int PW = $clog2(HALF_RANGE + 1) + 1;
  localparam logic signed [PW-1:0] HR_P = PW'(HALF_RANGE);
  localparam logic signed [PW-1:0] HR_N = -HR_P;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A reported position never leaves the saturation range.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_position <= HR_P) && (out_position >= HR_N))
    else $error("position out of range");

  // A stalled result holds its valid and its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position) &&
      $stable(out_bin_count) && $stable(out_position_sum) && $stable(out_step_count))
    else $error("stalled result changed");

  // The step count only falls on a restart, which reloads it with a delay.
  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) ##1 (out_valid && (out_step_count < $past(out_step_count)))
      |-> (out_step_count <= dfrw_pkg::STEP_W'(MAX_DELAY)))
    else $error("step count fell without restart");

endmodule

bind delayed_feedback_random_walk dfrw_chk #(
  .HALF_RANGE (HALF_RANGE),
  .MAX_DELAY  (MAX_DELAY)
) u_dfrw_chk (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the delayed-feedback random walk: directed and
// random requests on a valid/stall channel, checked against a local predictor.
// Depends on dfrw_pkg and delayed_feedback_random_walk.
`timescale 1ns / 1ps

module tb_top;
  import dfrw_pkg::*;

  localparam int HALF_RANGE = HALF_RANGE_DEF;
  localparam int MAX_DELAY  = MAX_DELAY_DEF;
  localparam int NBINS      = 2 * HALF_RANGE + 1;
  localparam int HDEPTH     = MAX_DELAY + 1;
  localparam int BIN_W      = $clog2(NBINS);
  localparam int POS_W      = $clog2(HALF_RANGE + 1) + 1;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int PHASE_ITEMS   = 255;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;

  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct packed {
    logic signed [POS_W-1:0]  position;
    logic [CNT_W-1:0]         bin_count;
    logic signed [SUM_W-1:0]  position_sum;
    logic [STEP_W-1:0]        step_count;
  } walk_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [RAND_W-1:0] rnd;
    logic [BIN_W-1:0]  bin;
    logic              known;
    walk_result_t      known_res;
  } walk_req_row_t;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic [DLY_W-1:0]  dly_a;
    logic [DLY_W-1:0]  dly_b;
    logic [WARM_W-1:0] warm;
    logic              restart;
  } walk_setting_t;

  // Result of any non-step request right after reset or restart with the
  // reset registers: position 1, nothing counted, step index at delay_a.
  localparam walk_result_t AFTER_RESET = '{5'sd1, 32'd0, 48'sd0, 40'd2};
  localparam walk_result_t PREDICTED   = '0;

  localparam int NDIRECTED = 22;
  localparam walk_req_row_t DIRECTED [NDIRECTED] = '{
    '{OP_READ,    32'd0,         5'd11, 1'b1, AFTER_RESET},
    '{OP_UNUSED,  32'hFFFF_FFFF, 5'd31, 1'b1, AFTER_RESET},
    '{OP_READ,    32'd0,         5'd31, 1'b1, AFTER_RESET},
    '{OP_READ,    32'hFFFF_FFFF, 5'd21, 1'b1, AFTER_RESET},
    '{OP_STEP,    32'd0,         5'd0,  1'b0, PREDICTED},
    '{OP_STEP,    32'hFFFF_FFFF, 5'd31, 1'b0, PREDICTED},
    '{OP_STEP,    32'h8000_0000, 5'd0,  1'b0, PREDICTED},
    '{OP_STEP,    32'h7FFF_FFFF, 5'd21, 1'b0, PREDICTED},
    '{OP_STEP,    32'h5555_5555, 5'd10, 1'b0, PREDICTED},
    '{OP_STEP,    32'hAAAA_AAAA, 5'd21, 1'b0, PREDICTED},
    '{OP_READ,    32'd0,         5'd0,  1'b0, PREDICTED},
    '{OP_READ,    32'd0,         5'd20, 1'b0, PREDICTED},
    '{OP_READ,    32'd0,         5'd10, 1'b0, PREDICTED},
    '{OP_RESTART, 32'd0,         5'd0,  1'b1, AFTER_RESET},
    '{OP_READ,    32'd0,         5'd11, 1'b1, AFTER_RESET},
    '{OP_STEP,    32'd0,         5'd0,  1'b0, PREDICTED},
    '{OP_STEP,    32'd0,         5'd0,  1'b0, PREDICTED},
    '{OP_STEP,    32'd0,         5'd0,  1'b0, PREDICTED},
    '{OP_READ,    32'd0,         5'd10, 1'b0, PREDICTED},
    '{OP_RESTART, 32'hFFFF_FFFF, 5'd31, 1'b1, AFTER_RESET},
    '{OP_STEP,    32'd1,         5'd0,  1'b0, PREDICTED},
    '{OP_UNUSED,  32'd0,         5'd0,  1'b0, PREDICTED}
  };

  // Register settings, one per random phase: free walk with the sum from the
  // first step, equal long delays, clamped delays with a sum never reached,
  // and mixed delays with small warmup indexes.
  localparam int NPHASES = 6;
  localparam walk_setting_t PHASES [NPHASES] = '{
    '{4'd10, 4'd0,  4'd0,  32'd0,         1'b1},
    '{4'd0,  4'd8,  4'd8,  32'd50,        1'b1},
    '{4'd15, 4'd15, 4'd3,  32'hFFFF_FFFF, 1'b0},
    '{4'd3,  4'd1,  4'd15, 32'd100,       1'b1},
    '{4'd5,  4'd4,  4'd7,  32'd8,         1'b0},
    '{4'd2,  4'd6,  4'd2,  32'd37,        1'b1}
  };

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] =
    '{CFG_THRESHOLD, CFG_DELAY_A, CFG_DELAY_B, CFG_WARMUP};

  logic clk;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_opcode = OP_STEP;
  logic [RAND_W-1:0]       in_rand_fraction = '0;
  logic [BIN_W-1:0]        in_bin_index = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [POS_W-1:0] out_position;
  logic [CNT_W-1:0]        out_bin_count;
  logic signed [SUM_W-1:0] out_position_sum;
  logic [STEP_W-1:0]       out_step_count;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Predictor state and its copy of the registers.
  logic signed [POS_W-1:0] pos_hist [HDEPTH];
  int                      hist_head;
  logic [STEP_W-1:0]       walk_steps;
  logic [CNT_W-1:0]        bin_visits [NBINS];
  logic signed [SUM_W-1:0] pos_sum;
  logic [THR_W-1:0]        walk_thr;
  logic [DLY_W-1:0]        walk_dly_a;
  logic [DLY_W-1:0]        walk_dly_b;
  logic [WARM_W-1:0]       walk_warm;

  walk_result_t walk_results_due [$];
  int mismatches   = 0;
  int results_seen = 0;
  int op_tally [4] = '{0, 0, 0, 0};

  delayed_feedback_random_walk dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_rand_fraction (in_rand_fraction),
    .in_bin_index     (in_bin_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_bin_count    (out_bin_count),
    .out_position_sum (out_position_sum),
    .out_step_count   (out_step_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Delays longer than the history are held at its depth.
  function automatic int limit_delay(logic [DLY_W-1:0] d);
    return (int'(d) > MAX_DELAY) ? MAX_DELAY : int'(d);
  endfunction

  // Saturating accumulate into the running sum.
  function automatic void add_to_sum(int p);
    longint s;
    s = longint'(pos_sum) + longint'(p);
    if (s > SUM_HI) s = SUM_HI;
    else if (s < SUM_LO) s = SUM_LO;
    pos_sum = SUM_W'(s);
  endfunction

  // Restart: history back to the single starting position, counts cleared.
  function automatic void rewind_walk();
    int da, db;
    da = limit_delay(walk_dly_a);
    db = limit_delay(walk_dly_b);
    foreach (pos_hist[i]) pos_hist[i] = '0;
    foreach (bin_visits[i]) bin_visits[i] = '0;
    hist_head = 0;
    pos_hist[0] = 5'sd1;
    walk_steps = STEP_W'((da > db) ? da : db);
    pos_sum = '0;
    if (walk_steps >= STEP_W'(walk_warm)) add_to_sum(1);
  endfunction

  // Applies one request to the predictor and returns the result it causes.
  function automatic walk_result_t apply_walk_request(logic [OP_W-1:0] op,
                                                      logic [RAND_W-1:0] rnd,
                                                      logic [BIN_W-1:0] bin);
    walk_result_t res;
    int thr, pa, pb, p, k;
    logic up_ok, down_ok, go_up;
    res = '0;
    case (op)
      OP_STEP: begin
        thr = int'(walk_thr);
        pa = pos_hist[(hist_head + HDEPTH - limit_delay(walk_dly_a)) % HDEPTH];
        pb = pos_hist[(hist_head + HDEPTH - limit_delay(walk_dly_b)) % HDEPTH];
        up_ok = (pa <= thr);
        down_ok = (pb >= -thr);
        if (up_ok && !down_ok) go_up = 1'b1;
        else if (down_ok && !up_ok) go_up = 1'b0;
        else go_up = (rnd < RAND_HALF);
        p = pos_hist[hist_head];
        p = go_up ? p + 1 : p - 1;
        if (p > HALF_RANGE) p = HALF_RANGE;
        if (p < -HALF_RANGE) p = -HALF_RANGE;
        hist_head = (hist_head + 1) % HDEPTH;
        pos_hist[hist_head] = POS_W'(p);
        if (walk_steps != '1) walk_steps = walk_steps + 1'b1;
        k = p + HALF_RANGE;
        if (bin_visits[k] != '1) bin_visits[k] = bin_visits[k] + 1'b1;
        res.bin_count = bin_visits[k];
        if (walk_steps >= STEP_W'(walk_warm)) add_to_sum(p);
      end
      OP_RESTART: rewind_walk();
      OP_READ: begin
        if (int'(bin) < NBINS) res.bin_count = bin_visits[bin];
      end
      default: ;
    endcase
    res.position = pos_hist[hist_head];
    res.position_sum = pos_sum;
    res.step_count = walk_steps;
    return res;
  endfunction

  // Presents one request, waits for it to be taken, then records what it
  // should produce: the typed value where the row has one, else the prediction.
  task automatic submit_request(logic [OP_W-1:0] op, logic [RAND_W-1:0] rnd,
                                logic [BIN_W-1:0] bin, logic known,
                                walk_result_t known_res);
    walk_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_rand_fraction <= rnd;
    in_bin_index <= bin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = apply_walk_request(op, rnd, bin);
    walk_results_due.push_back(known ? known_res : want);
    op_tally[op]++;
  endtask

  // Holds the sender until every pending result has arrived.
  task automatic drain_walk();
    in_valid <= 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers, with junk above the narrow fields.
  task automatic write_walk_config(walk_setting_t s);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[0] = ($urandom() & 32'hFFFF_FFF0) | CFG_DATA_W'(s.thr);
    vals[1] = ($urandom() & 32'hFFFF_FFF0) | CFG_DATA_W'(s.dly_a);
    vals[2] = ($urandom() & 32'hFFFF_FFF0) | CFG_DATA_W'(s.dly_b);
    vals[3] = s.warm;
    cfg_we <= 1'b1;
    foreach (REG_ORDER[i]) begin
      cfg_index <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    walk_thr = s.thr;
    walk_dly_a = s.dly_a;
    walk_dly_b = s.dly_b;
    walk_warm = s.warm;
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compares each accepted result with the oldest pending one.
  always @(posedge clk) begin : check_results
    walk_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_position, out_bin_count, out_position_sum, out_step_count};
      results_seen++;
      if (walk_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, position %0d bin_count %0d sum %0d step %0d",
                   $time, got.position, got.bin_count, got.position_sum,
                   got.step_count);
      end else begin
        want = walk_results_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: result %0d: position exp %0d got %0d, bin_count exp %0d ",
                      "got %0d, sum exp %0d got %0d, step exp %0d got %0d"},
                     $time, results_seen, want.position, got.position,
                     want.bin_count, got.bin_count, want.position_sum,
                     got.position_sum, want.step_count, got.step_count);
        end
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int up_pct, sel;
    logic [OP_W-1:0]   op;
    logic [RAND_W-1:0] rnd;
    logic [BIN_W-1:0]  bin;

    walk_thr = THRESHOLD_RST;
    walk_dly_a = DELAY_A_RST;
    walk_dly_b = DELAY_B_RST;
    walk_warm = WARMUP_RST;
    rewind_walk();
    up_pct = 50;

    // Sender mostly busy, receiver mostly stalled.
    send_idle_pct = 7;
    recv_stall_pct = 83;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset register values.
    foreach (DIRECTED[i])
      submit_request(DIRECTED[i].op, DIRECTED[i].rnd, DIRECTED[i].bin,
                     DIRECTED[i].known, DIRECTED[i].known_res);
    drain_walk();

    for (int ph = 0; ph < NPHASES; ph++) begin
      // Two phases per idling pattern: as above, then reversed, then none.
      case (ph / 2)
        0: begin send_idle_pct = 7;  recv_stall_pct = 83; end
        1: begin send_idle_pct = 83; recv_stall_pct = 7;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_walk_config(PHASES[ph]);
      if (PHASES[ph].restart)
        submit_request(OP_RESTART, $urandom(), BIN_W'($urandom_range(31, 0)),
                       1'b0, PREDICTED);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Change the drift every few dozen steps so the walk reaches both rails.
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: up_pct = 8;
            1: up_pct = 50;
            default: up_pct = 92;
          endcase
        end
        sel = $urandom_range(99);
        bin = BIN_W'($urandom_range(31, 0));
        rnd = $urandom();
        if (sel < 74) begin
          op = OP_STEP;
          rnd = ($urandom_range(99) < up_pct) ? $urandom_range(32'h7FFF_FFFF, 0)
                                              : $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
        end else if (sel < 94) begin
          op = OP_READ;
          if ($urandom_range(9) != 0) bin = BIN_W'($urandom_range(NBINS - 1, 0));
        end else if (sel < 97) begin
          op = OP_RESTART;
        end else begin
          op = OP_UNUSED;
        end
        submit_request(op, rnd, bin, 1'b0, PREDICTED);
      end
      drain_walk();
    end

    if (walk_results_due.size() != 0) begin
      mismatches += walk_results_due.size();
      $display("%0d results never arrived", walk_results_due.size());
    end
    $display("Covered %0d steps, %0d restarts, %0d bin reads, %0d unused opcodes",
             op_tally[OP_STEP], op_tally[OP_RESTART], op_tally[OP_READ],
             op_tally[OP_UNUSED]);
    $display("over %0d register settings; %0d results compared, %0d mismatches.",
             NPHASES + 1, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
